### hdl/dlr_pkg.sv
package dlr_pkg;

    localparam int LABEL_W         = 10;
    localparam int COUNT_W         = 11;
    localparam int EPOCH_W         = 8;
    localparam int LABEL_SPACE_DEF = 1024;

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } t_state;

    typedef struct packed {
        logic [EPOCH_W-1:0] epoch;
        logic [LABEL_W-1:0] dense;
    } t_entry;

endpackage

### hdl/dlr_in_if.sv
interface dlr_in_if
    import dlr_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [LABEL_W-1:0] label;
    logic               run_end;

    modport source (output valid, output label, output run_end, input ready);
    modport sink   (input valid, input label, input run_end, output ready);
endinterface

### hdl/dlr_out_if.sv
interface dlr_out_if
    import dlr_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [LABEL_W-1:0] dense_label;
    logic [COUNT_W-1:0] unique_count;
    logic               run_done;

    modport source (output valid, output dense_label, output unique_count,
                     output run_done, input ready);
    modport sink   (input valid, input dense_label, input unique_count,
                     input run_done, output ready);
endinterface

### hdl/dlr_ram.sv
module dlr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/dense_label_renumber_unit.sv
// Renumbers a run of labels densely in order of first appearance. Sustained
// rate is one label per cycle while the output is ready; a result passes
// through the table read, then the output register. The table is one memory
// holding a dense number and a run tag per label; a label counts as seen when
// its tag matches the current run tag, and the last table write is forwarded
// so that a repeated label needs no stall. After reset, and after every
// 255th run, a clearing pass rewrites all min(LABEL_SPACE, 1024) tags while
// input ready stays low.
module dense_label_renumber_unit
    import dlr_pkg::*;
#(
    parameter int LABEL_SPACE = LABEL_SPACE_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    dlr_in_if.sink         i_in,
    dlr_out_if.source      o_out
);

    localparam int DEPTH  = (LABEL_SPACE < (1 << LABEL_W)) ? LABEL_SPACE : (1 << LABEL_W);
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int ENT_W  = EPOCH_W + LABEL_W;

    localparam logic [EPOCH_W-1:0] EPOCH_MAX = {EPOCH_W{1'b1}};
    localparam logic [EPOCH_W-1:0] EPOCH_ONE = EPOCH_W'(1);
    localparam logic [ADDR_W-1:0]  ADDR_LAST = ADDR_W'(DEPTH - 1);

    t_state             r_state, n_state;
    logic [ADDR_W-1:0]  r_clr_addr;
    logic [EPOCH_W-1:0] r_epoch;
    logic [COUNT_W-1:0] r_count;

    logic               r_s1_vld;
    logic [ADDR_W-1:0]  r_s1_addr;
    logic               r_s1_inr;
    logic               r_s1_end;

    logic               r_fw_vld;
    logic [ADDR_W-1:0]  r_fw_addr;
    t_entry             r_fw_data;

    logic               r_out_vld;
    logic [LABEL_W-1:0] r_out_dense;
    logic [COUNT_W-1:0] r_out_count;
    logic               r_out_done;

    logic               in_xfer;
    logic               s1_fire;
    logic               wrap;
    logic [ENT_W-1:0]   rd_raw;
    t_entry             rd_ent;
    t_entry             cur_ent;
    logic               seen;
    logic               is_new;
    logic [LABEL_W-1:0] dense;
    logic [COUNT_W-1:0] count_nxt;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    t_entry             ram_wdata;

    dlr_ram #(
        .WIDTH (ENT_W),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (in_xfer),
        .i_raddr (i_in.label[ADDR_W-1:0]),
        .o_rdata (rd_raw)
    );

    assign rd_ent  = t_entry'(rd_raw);
    assign cur_ent = (r_fw_vld && r_fw_addr == r_s1_addr) ? r_fw_data : rd_ent;
    assign seen    = r_s1_inr && cur_ent.epoch == r_epoch;
    assign is_new  = r_s1_inr && !seen;
    assign dense   = seen ? cur_ent.dense : (is_new ? r_count[LABEL_W-1:0] : '0);
    assign count_nxt = is_new ? r_count + COUNT_W'(1) : r_count;

    assign s1_fire = r_s1_vld && (!r_out_vld || o_out.ready);
    assign wrap    = r_s1_vld && r_s1_end && r_epoch == EPOCH_MAX;
    assign i_in.ready = r_state == ST_RUN && !wrap && (!r_s1_vld || s1_fire);
    assign in_xfer = i_in.valid && i_in.ready;

    always_comb begin
        if (r_state == ST_CLEAR) begin
            ram_we          = 1'b1;
            ram_waddr       = r_clr_addr;
            ram_wdata.epoch = '0;
            ram_wdata.dense = '0;
        end else begin
            ram_we          = s1_fire && is_new;
            ram_waddr       = r_s1_addr;
            ram_wdata.epoch = r_epoch;
            ram_wdata.dense = r_count[LABEL_W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == ADDR_LAST) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (s1_fire && wrap) begin
                    n_state = ST_CLEAR;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_epoch    <= EPOCH_ONE;
            r_count    <= '0;
            r_s1_vld   <= 1'b0;
            r_fw_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
                r_fw_vld   <= 1'b0;
                if (r_clr_addr == ADDR_LAST) begin
                    r_epoch <= EPOCH_ONE;
                end
            end else begin
                if (s1_fire && is_new) begin
                    r_fw_vld <= 1'b1;
                end
                if (s1_fire && r_s1_end) begin
                    r_epoch    <= r_epoch + EPOCH_ONE;
                    r_clr_addr <= '0;
                end
            end
            if (s1_fire) begin
                r_count <= r_s1_end ? '0 : count_nxt;
            end
            if (in_xfer) begin
                r_s1_vld <= 1'b1;
            end else if (s1_fire) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_fire) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_addr <= i_in.label[ADDR_W-1:0];
            r_s1_inr  <= {1'b0, i_in.label} < COUNT_W'(DEPTH);
            r_s1_end  <= i_in.run_end;
        end
        if (s1_fire && is_new) begin
            r_fw_addr       <= r_s1_addr;
            r_fw_data.epoch <= r_epoch;
            r_fw_data.dense <= r_count[LABEL_W-1:0];
        end
        if (s1_fire) begin
            r_out_dense <= dense;
            r_out_count <= count_nxt;
            r_out_done  <= r_s1_end;
        end
    end

    assign o_out.valid        = r_out_vld;
    assign o_out.dense_label  = r_out_dense;
    assign o_out.unique_count = r_out_count;
    assign o_out.run_done     = r_out_done;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_W'(DEPTH))
        else $error("unique count exceeds table depth");

    a_no_xfer_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_CLEAR |-> !i_in.ready)
        else $error("input ready during clearing pass");

    a_run_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire && r_s1_end |=> r_count == '0)
        else $error("count not cleared after run end");

    a_epoch_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_RUN |-> r_epoch != '0)
        else $error("run tag equals cleared tag");

endmodule
